// File: hdl/pva_pkg.sv
// Package for the polyphonic voice allocator: command codes, queue entry type,
// time constants and the note-to-pitch conversion.
// No dependencies.
package pva_pkg;

    typedef enum logic [1:0] {
        OP_ON   = 2'd0,
        OP_OFF  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;

    localparam logic [30:0] HELD_KEY  = 31'h7FFF_FFFF;
    localparam int          QDEPTH    = 2;

    typedef struct packed {
        op_t         op;
        logic [6:0]  note;
        logic [2:0]  voice;
        logic [30:0] now;
    } entry_t;

    // round((note - 49) * 32768 / 120): 32768 = 120 * 273 + 8
    function automatic logic [15:0] note_pitch(input logic [6:0] n);
        logic        neg;
        logic [6:0]  mag;
        logic [7:0]  y;
        logic [2:0]  frac;
        logic [15:0] q;
        neg  = (n < 7'd49);
        mag  = neg ? (7'd49 - n) : (n - 7'd49);
        y    = {mag, 1'b0} + 8'd15;
        frac = 3'(y >= 8'd30) + 3'(y >= 8'd60) + 3'(y >= 8'd90)
             + 3'(y >= 8'd120) + 3'(y >= 8'd150);
        q    = (16'(mag) * 16'd273) + 16'(frac);
        return neg ? (16'd0 - q) : q;
    endfunction

endpackage

// File: hdl/pva_front.sv
// Front end of the voice allocator: accepts note transactions, classifies them
// and holds them in a two-entry queue for the back end. Uses pva_pkg.
module pva_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       command,
    input  logic [6:0]       note,
    input  logic [6:0]       velocity,
    input  logic [2:0]       voice,
    input  logic [30:0]      now,
    output logic             q_valid,
    output pva_pkg::entry_t  q_entry,
    input  logic             q_pop
);

    pva_pkg::entry_t queue_reg [pva_pkg::QDEPTH];
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic            push;
    logic            pop;
    pva_pkg::entry_t entry_in;

    always_comb
    begin
        entry_in.note  = note;
        entry_in.voice = voice;
        entry_in.now   = now;
        unique case (command)
            pva_pkg::CMD_NOTE_ON:
                entry_in.op = (velocity != 7'd0) ? pva_pkg::OP_ON : pva_pkg::OP_OFF;
            pva_pkg::CMD_NOTE_OFF:
                entry_in.op = pva_pkg::OP_OFF;
            pva_pkg::CMD_READ:
                entry_in.op = pva_pkg::OP_READ;
            default:
                entry_in.op = pva_pkg::OP_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'(pva_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// File: hdl/pva_back.sv
// Back end of the voice allocator: voice state, oldest-release scan, note-off
// release, voice read and the result register. Uses pva_pkg.
module pva_back
#(
    parameter int VOICES = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  pva_pkg::entry_t  q_entry,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       voice_index,
    output logic [15:0]      pitch,
    output logic             gate,
    output logic [7:0]       released_mask
);

    localparam int IW = $clog2(VOICES);
    localparam int MW = (VOICES < 8) ? VOICES : 8;
    localparam logic [IW-1:0] LAST = IW'(VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t        state_reg;
    state_t        state_next;

    logic [6:0]    slot_note_reg    [VOICES];
    logic [30:0]   release_time_reg [VOICES];
    logic          held_reg         [VOICES];
    logic [15:0]   voice_pitch_reg  [VOICES];
    logic          voice_gate_reg   [VOICES];

    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] best_reg;
    logic [30:0]   best_key_reg;
    logic [6:0]    note_reg;

    logic [2:0]    res_index_reg;
    logic [15:0]   res_pitch_reg;
    logic          res_gate_reg;
    logic [7:0]    res_mask_reg;

    logic          out_valid_reg;
    logic [2:0]    out_index_reg;
    logic [15:0]   out_pitch_reg;
    logic          out_gate_reg;
    logic [7:0]    out_mask_reg;

    logic [VOICES-1:0] match;
    logic [30:0]   key0;
    logic [30:0]   key_ptr;
    logic          less;
    logic [IW-1:0] best_fin;
    logic [15:0]   new_pitch;
    logic [5:0]    voice_ext;
    logic          rd_in_range;
    logic [IW-1:0] rd_idx;
    logic          is_read;
    logic          out_free;
    logic          start;

    always_comb
    begin
        for (int i = 0; i < VOICES; i++)
        begin
            match[i] = (slot_note_reg[i] == q_entry.note);
        end
    end

    assign key0        = held_reg[0] ? pva_pkg::HELD_KEY : release_time_reg[0];
    assign key_ptr     = held_reg[ptr_reg] ? pva_pkg::HELD_KEY : release_time_reg[ptr_reg];
    assign less        = (key_ptr < best_key_reg);
    assign best_fin    = less ? ptr_reg : best_reg;
    assign new_pitch   = pva_pkg::note_pitch(note_reg);
    assign voice_ext   = 6'(q_entry.voice);
    assign rd_in_range = (voice_ext < 6'(VOICES));
    assign rd_idx      = voice_ext[IW-1:0];
    assign is_read     = (q_entry.op == pva_pkg::OP_READ);
    assign out_free    = !out_valid_reg || !out_stall;
    assign start       = (state_reg == S_IDLE) && q_valid;
    assign q_pop       = start;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_entry.op == pva_pkg::OP_ON) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (ptr_reg == LAST)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                slot_note_reg[i]    <= 7'd0;
                release_time_reg[i] <= 31'd0;
                held_reg[i]         <= 1'b0;
                voice_pitch_reg[i]  <= 16'd0;
                voice_gate_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // release every voice holding the note
            if (start && (q_entry.op == pva_pkg::OP_OFF))
            begin
                for (int i = 0; i < VOICES; i++)
                begin
                    if (match[i])
                    begin
                        release_time_reg[i] <= q_entry.now;
                        held_reg[i]         <= 1'b0;
                        voice_gate_reg[i]   <= 1'b0;
                    end
                end
            end

            // claim the oldest voice
            if ((state_reg == S_SCAN) && (ptr_reg == LAST))
            begin
                slot_note_reg[best_fin]   <= note_reg;
                held_reg[best_fin]        <= 1'b1;
                voice_pitch_reg[best_fin] <= new_pitch;
                voice_gate_reg[best_fin]  <= 1'b1;
            end

            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            note_reg      <= q_entry.note;
            ptr_reg       <= IW'(1);
            best_reg      <= '0;
            best_key_reg  <= key0;
            res_index_reg <= is_read ? q_entry.voice : 3'd0;
            res_pitch_reg <= (is_read && rd_in_range) ? voice_pitch_reg[rd_idx] : 16'd0;
            res_gate_reg  <= (is_read && rd_in_range) ? voice_gate_reg[rd_idx] : 1'b0;
            res_mask_reg  <= (q_entry.op == pva_pkg::OP_OFF) ? 8'(match[MW-1:0]) : 8'd0;
        end

        if (state_reg == S_SCAN)
        begin
            ptr_reg      <= ptr_reg + IW'(1);
            best_reg     <= best_fin;
            best_key_reg <= less ? key_ptr : best_key_reg;
            if (ptr_reg == LAST)
            begin
                res_index_reg <= 3'(best_fin);
                res_pitch_reg <= new_pitch;
                res_gate_reg  <= 1'b1;
                res_mask_reg  <= 8'd0;
            end
        end

        if ((state_reg == S_EMIT) && out_free)
        begin
            out_index_reg <= res_index_reg;
            out_pitch_reg <= res_pitch_reg;
            out_gate_reg  <= res_gate_reg;
            out_mask_reg  <= res_mask_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign voice_index   = out_index_reg;
    assign pitch         = out_pitch_reg;
    assign gate          = out_gate_reg;
    assign released_mask = out_mask_reg;

endmodule

// File: hdl/poly_voice_allocator.sv
// Polyphonic voice allocator top level: joins the front queue and the back end.
// Commands are handled one at a time by the back end: a note on scans one voice key
// per cycle, then emits its result; other commands go straight to the result. A two-entry
// queue in front absorbs bursts while the back end is busy.
// Reset: rst_n clears all voice state, empties the queue and clears the output valid flag at once.
// Depends on pva_pkg, pva_front and pva_back.
module poly_voice_allocator
#(
    parameter int VOICES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [6:0]         note,
    input  logic [6:0]         velocity,
    input  logic [2:0]         voice,
    input  logic [30:0]        now,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         voice_index,
    output logic signed [15:0] pitch,
    output logic               gate,
    output logic [7:0]         released_mask
);

    logic            q_valid;
    logic            q_pop;
    pva_pkg::entry_t q_entry;
    logic [15:0]     pitch_bits;

    pva_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .note     (note),
        .velocity (velocity),
        .voice    (voice),
        .now      (now),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    pva_back
    #(
        .VOICES (VOICES)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .voice_index   (voice_index),
        .pitch         (pitch_bits),
        .gate          (gate),
        .released_mask (released_mask)
    );

    assign pitch = signed'(pitch_bits);

endmodule

// File: tb/tb_poly_voice_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench for poly_voice_allocator: directed and random note events,
// checked against an in-bench voice allocation predictor. Depends on pva_pkg and the RTL.
module tb_poly_voice_allocator;

    localparam int          NUM_VOICES    = 8;
    localparam int          RANDOM_EVENTS = 1680;
    localparam int unsigned WATCHDOG_MAX  = 3000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned HOLD_AFTER    = 500;
    localparam int unsigned TAIL_CYCLES   = 24;

    typedef struct {
        pva_pkg::op_t cmd;
        bit [6:0]     note;
        bit [6:0]     velocity;
        bit [2:0]     voice;
        bit [30:0]    now;
        bit           wait_drain;
    } note_event_t;

    typedef struct {
        bit [2:0]   voice_index;
        bit [15:0]  pitch;
        bit         gate;
        bit [7:0]   released_mask;
    } voice_report_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [1:0]         command       = '0;
    logic [6:0]         note          = '0;
    logic [6:0]         velocity      = '0;
    logic [2:0]         voice         = '0;
    logic [30:0]        now           = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [2:0]         voice_index;
    logic signed [15:0] pitch;
    logic               gate;
    logic [7:0]         released_mask;

    bit [6:0]           voice_note      [NUM_VOICES];
    bit [30:0]          voice_released  [NUM_VOICES];
    bit                 voice_held      [NUM_VOICES];
    bit [15:0]          voice_pitch_q   [NUM_VOICES];
    bit                 voice_gate_open [NUM_VOICES];

    note_event_t        queued_note_events[$];
    voice_report_t      pending_voice_reports[$];
    note_event_t        event_on_bus;

    int unsigned        send_gap;
    int unsigned        stall_left;
    int unsigned        hold_cycles;
    bit                 hold_done;
    int unsigned        reports_seen;
    int unsigned        mismatches;
    int unsigned        quiet_cycles = 0;
    int unsigned        cycle_count  = 0;
    logic               calm;

    poly_voice_allocator #(.VOICES(NUM_VOICES)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .note          (note),
        .velocity      (velocity),
        .voice         (voice),
        .now           (now),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .voice_index   (voice_index),
        .pitch         (pitch),
        .gate          (gate),
        .released_mask (released_mask)
    );

    always #4 clk = ~clk;

    assign calm = (cycle_count[11:10] == 2'b01);

    function automatic bit [15:0] q15_pitch(input bit [6:0] n);
        int          d;
        int unsigned mag;
        int unsigned q;
        d   = int'(n) - 49;
        mag = (d < 0) ? (-d) * 32768 : d * 32768;
        q   = (mag + 60) / 120;
        return (d < 0) ? (16'd0 - 16'(q)) : 16'(q);
    endfunction

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void predict_voice_event(input note_event_t ev);
        voice_report_t rep;
        int            best;
        bit [30:0]     best_key;
        bit [30:0]     key;
        rep = '{default: '0};
        if (ev.cmd == pva_pkg::OP_ON && ev.velocity != 0) begin
            best     = 0;
            best_key = voice_held[0] ? pva_pkg::HELD_KEY : voice_released[0];
            for (int i = 1; i < NUM_VOICES; i++) begin
                key = voice_held[i] ? pva_pkg::HELD_KEY : voice_released[i];
                if (key < best_key) begin
                    best_key = key;
                    best     = i;
                end
            end
            voice_note[best]      = ev.note;
            voice_held[best]      = 1'b1;
            voice_pitch_q[best]   = q15_pitch(ev.note);
            voice_gate_open[best] = 1'b1;
            rep.voice_index       = 3'(best);
            rep.pitch             = voice_pitch_q[best];
            rep.gate              = 1'b1;
        end else if (ev.cmd == pva_pkg::OP_ON || ev.cmd == pva_pkg::OP_OFF) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                if (voice_note[i] == ev.note) begin
                    voice_released[i]  = ev.now;
                    voice_held[i]      = 1'b0;
                    voice_gate_open[i] = 1'b0;
                    if (i < 8)
                        rep.released_mask[i] = 1'b1;
                end
            end
        end else if (ev.cmd == pva_pkg::OP_READ) begin
            rep.voice_index = ev.voice;
            if (ev.voice < NUM_VOICES) begin
                rep.pitch = voice_pitch_q[ev.voice];
                rep.gate  = voice_gate_open[ev.voice];
            end
        end
        pending_voice_reports.push_back(rep);
    endfunction

    function automatic void queue_event(input pva_pkg::op_t c, input bit [6:0] n,
                                        input bit [6:0] v, input bit [2:0] vc,
                                        input bit [30:0] t, input bit drain);
        note_event_t ev;
        ev.cmd        = c;
        ev.note       = n;
        ev.velocity   = v;
        ev.voice      = vc;
        ev.now        = t;
        ev.wait_drain = drain;
        queued_note_events.push_back(ev);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= '0;
            note     <= '0;
            velocity <= '0;
            voice    <= '0;
            now      <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_voice_event(event_on_bus);
            if (in_valid && in_stall)
            begin
                // hold the stalled transaction
            end
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (queued_note_events.size() != 0 &&
                     !(queued_note_events[0].wait_drain && pending_voice_reports.size() != 0))
            begin
                event_on_bus <= queued_note_events[0];
                command      <= queued_note_events[0].cmd;
                note         <= queued_note_events[0].note;
                velocity     <= queued_note_events[0].velocity;
                voice        <= queued_note_events[0].voice;
                now          <= queued_note_events[0].now;
                in_valid     <= 1'b1;
                send_gap     <= calm ? 0 : idle_span();
                void'(queued_note_events.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off, started once after enough results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (!hold_done && reports_seen >= HOLD_AFTER)
        begin
            hold_cycles <= LONG_HOLD;
            hold_done   <= 1'b1;
        end
        else if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        voice_report_t exp_rep;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_left   <= 0;
            reports_seen <= 0;
            mismatches   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                reports_seen <= reports_seen + 1;
                if (pending_voice_reports.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: voice_index %0d pitch %0d gate %0d mask %02h",
                                 voice_index, pitch, gate, released_mask);
                end
                else
                begin
                    exp_rep = pending_voice_reports.pop_front();
                    if (voice_index !== exp_rep.voice_index || pitch !== exp_rep.pitch ||
                        gate !== exp_rep.gate || released_mask !== exp_rep.released_mask)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"mismatch at result %0d: voice_index exp %0d got %0d, ",
                                      "pitch exp %0d got %0d, gate exp %0d got %0d, ",
                                      "mask exp %02h got %02h"},
                                     reports_seen, exp_rep.voice_index, voice_index,
                                     $signed(exp_rep.pitch), pitch, exp_rep.gate, gate,
                                     exp_rep.released_mask, released_mask);
                    end
                end
            end
            if (hold_cycles != 0)
                out_stall <= 1'b1;
            else if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                out_stall  <= 1'b1;
                stall_left <= idle_span();
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        bit [30:0]   stamp;
        bit [6:0]    n;
        bit [6:0]    held_notes[$];
        int          idx;
        bit          drain;

        // directed part
        queue_event(pva_pkg::OP_READ, 7'd0, 7'd0, 3'd0, 31'd0, 1'b0);
        queue_event(pva_pkg::OP_OFF, 7'd0, 7'd127, 3'd7, 31'd5, 1'b0);
        queue_event(pva_pkg::OP_ON, 7'd0, 7'd127, 3'd0, 31'd6, 1'b0);
        queue_event(pva_pkg::OP_ON, 7'd127, 7'd1, 3'd5, 31'd7, 1'b0);
        queue_event(pva_pkg::OP_ON, 7'd49, 7'd64, 3'd2, 31'd8, 1'b0);
        queue_event(pva_pkg::OP_ON, 7'd60, 7'd0, 3'd1, 31'd9, 1'b0);
        queue_event(pva_pkg::OP_OFF, 7'd127, 7'd0, 3'd0, 31'h7FFF_FFFF, 1'b0);
        queue_event(pva_pkg::OP_NOP, 7'h7F, 7'h7F, 3'h7, 31'h7FFF_FFFF, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_event(pva_pkg::OP_ON, 7'(i + 1), 7'(i * 20 + 3), 3'(i), 31'(10 + i), 1'b0);
        queue_event(pva_pkg::OP_ON, 7'd100, 7'd99, 3'd3, 31'd20, 1'b0);
        for (int i = 0; i < NUM_VOICES; i++)
            queue_event(pva_pkg::OP_READ, 7'(i * 9), 7'd0, 3'(i), 31'(21 + i), 1'b0);

        // random part: mostly note on / note off pairs with rising timestamps
        stamp = 31'd100;
        for (int k = 0; k < RANDOM_EVENTS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 90)
                stamp = stamp + 31'($urandom_range(0, 500));
            else
                stamp = stamp + 31'($urandom_range(1000, 5000000));
            if (stamp > 31'h7FF0_0000)
                stamp = 31'($urandom_range(0, 1000));
            drain = (k == RANDOM_EVENTS / 2);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                n = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(48, 72))
                                                 : 7'($urandom_range(0, 127));
                held_notes.push_back(n);
                if (held_notes.size() > 12)
                    void'(held_notes.pop_front());
                queue_event(pva_pkg::OP_ON, n, 7'($urandom_range(1, 127)), 3'($urandom),
                            stamp, drain);
            end
            else if (r < 75)
            begin
                if (held_notes.size() != 0)
                begin
                    idx = $urandom_range(0, held_notes.size() - 1);
                    n   = held_notes[idx];
                    held_notes.delete(idx);
                end
                else
                    n = 7'($urandom_range(0, 127));
                if ($urandom_range(0, 3) == 0)
                    queue_event(pva_pkg::OP_ON, n, 7'd0, 3'($urandom), stamp, drain);
                else
                    queue_event(pva_pkg::OP_OFF, n, 7'($urandom), 3'($urandom), stamp, drain);
            end
            else if (r < 90)
                queue_event(pva_pkg::OP_READ, 7'($urandom), 7'($urandom), 3'($urandom),
                            stamp, drain);
            else if (r < 94)
                queue_event(pva_pkg::OP_NOP, 7'($urandom), 7'($urandom), 3'($urandom),
                            31'($urandom), drain);
            else
                queue_event(pva_pkg::op_t'($urandom_range(0, 3)), 7'($urandom),
                            7'($urandom), 3'($urandom), 31'($urandom), drain);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (queued_note_events.size() == 0);
        @(posedge clk);
        while (in_valid || pending_voice_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hdl/pva_pkg.sv
hdl/pva_front.sv
hdl/pva_back.sv
hdl/poly_voice_allocator.sv
tb/tb_poly_voice_allocator.sv
